// File: rtl/core/lndl_pkg.sv
// shared types and constants for the name directory lookup block
package lndl_pkg;

  // request codes carried by in_req_type
  typedef enum logic [0:0] {
    REQ_LOAD   = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e_t;

  // back end sequencer states
  typedef enum logic [0:0] {
    B_IDLE = 1'b0,
    B_SCAN = 1'b1
  } back_state_t;

  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int DATA_W  = 32;
  localparam int NAME_W  = 64;
  localparam int ENTRY_W = NAME_W + 2 * DATA_W;

  // queue between front and back: two words, so each side stalls on its own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one classified word handed from front to back
  typedef struct packed {
    req_e_t                op;
    logic [IDX_W-1:0]      index;
    logic [DATA_W-1:0]     pos;
    logic [DATA_W-1:0]     size;
    logic [NAME_W-1:0]     name;
    logic                  too_long;
  } q_word_t;

  // queue status seen by the back end
  typedef struct packed {
    logic    valid;
    q_word_t word;
  } q_head_t;

endpackage

// File: rtl/core/lndl_ram.sv
// generic single write port, single read port ram with registered read
module lndl_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lndl_front.sv
// front end: takes a command word, drops out-of-range loads, packs the queue word
module lndl_front #(
  parameter int DIR_DEPTH = 4096
) (
  input  logic                         start,
  input  logic                         q_full,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [lndl_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [lndl_pkg::DATA_W-1:0]  in_entry_pos,
  input  logic [lndl_pkg::DATA_W-1:0]  in_entry_size,
  input  logic [lndl_pkg::NAME_W-1:0]  in_name_bytes,
  input  logic                         in_name_too_long,
  output logic                         q_push,
  output lndl_pkg::q_word_t            q_word
);

  logic           accept;
  logic           load_in_range;
  lndl_pkg::req_e_t op;

  assign busy          = q_full;
  assign accept        = start && !q_full;
  assign op            = lndl_pkg::req_e_t'(in_req_type);
  assign load_in_range = 32'(in_entry_index) < 32'(DIR_DEPTH);

  // loads past the directory end are dropped here and never reach the back
  assign q_push = accept && ((op == lndl_pkg::REQ_LOOKUP) || load_in_range);

  always_comb begin
    q_word          = '0;
    q_word.op       = op;
    q_word.index    = in_entry_index;
    q_word.pos      = in_entry_pos;
    q_word.size     = in_entry_size;
    q_word.name     = in_name_bytes;
    q_word.too_long = in_name_too_long;
  end

endmodule

// File: rtl/core/lndl_fifo.sv
// two-word queue between front and back
module lndl_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lndl_pkg::q_word_t push_word,
  output logic              full,
  input  logic              pop,
  output lndl_pkg::q_head_t head
);

  lndl_pkg::q_word_t                 mem_r [lndl_pkg::QUEUE_DEPTH];
  logic [lndl_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [lndl_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [lndl_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == lndl_pkg::QCNT_W'(lndl_pkg::QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + lndl_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + lndl_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + lndl_pkg::QCNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - lndl_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// File: rtl/core/lndl_back.sv
// back end: writes loads into the directory ram and walks it for lookups
module lndl_back #(
  parameter int DIR_DEPTH  = 4096,
  parameter int NAME_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lndl_pkg::q_head_t           head,
  output logic                        pop,
  input  logic [lndl_pkg::CNT_W-1:0]  entry_count,
  output logic                        out_strobe,
  output logic                        out_found,
  output logic [lndl_pkg::IDX_W-1:0]  out_match_index,
  output logic [lndl_pkg::DATA_W-1:0] out_match_pos,
  output logic [lndl_pkg::DATA_W-1:0] out_match_size
);

  localparam int AW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_UA = 8'h41;

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= CH_LA && c <= CH_LZ) begin
      return c - CH_LA + CH_UA;
    end
    return c;
  endfunction

  lndl_pkg::back_state_t          state_r, state_nxt;
  logic [AW-1:0]                  pend_idx_r, pend_idx_nxt;
  logic [lndl_pkg::NAME_W-1:0]    q_name_r, q_name_nxt;
  logic                           q_long_r, q_long_nxt;

  logic                           ram_we;
  logic                           ram_re;
  logic [AW-1:0]                  ram_waddr;
  logic [AW-1:0]                  ram_raddr;
  logic [lndl_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [lndl_pkg::ENTRY_W-1:0]   ram_rdata;

  logic [lndl_pkg::NAME_W-1:0]    st_name;
  logic [lndl_pkg::DATA_W-1:0]    st_pos;
  logic [lndl_pkg::DATA_W-1:0]    st_size;

  logic [CW-1:0]                  cnt_sat;
  logic [AW-1:0]                  last_addr;
  logic                           hit;

  logic                           res_strobe;
  logic                           res_found;
  logic [AW-1:0]                  res_idx;
  logic [lndl_pkg::DATA_W-1:0]    res_pos;
  logic [lndl_pkg::DATA_W-1:0]    res_size;

  logic                           strobe_r;
  logic                           found_r;
  logic [lndl_pkg::IDX_W-1:0]     idx_r;
  logic [lndl_pkg::DATA_W-1:0]    pos_r;
  logic [lndl_pkg::DATA_W-1:0]    size_r;

  lndl_ram #(
    .WIDTH (lndl_pkg::ENTRY_W),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = AW'(head.word.index);
  assign ram_wdata = {head.word.name, head.word.pos, head.word.size};
  assign {st_name, st_pos, st_size} = ram_rdata;

  // entry count above the depth saturates
  assign cnt_sat   = (32'(entry_count) > 32'(DIR_DEPTH)) ? CW'(DIR_DEPTH) : CW'(entry_count);
  assign last_addr = AW'(cnt_sat - CW'(1));

  // byte compare, stops at the first query nul or mismatch
  always_comb begin
    logic       done;
    logic [7:0] s;
    logic [7:0] q;
    done = 1'b0;
    hit  = !q_long_r;
    for (int i = 0; i < NAME_BYTES; i++) begin
      s = fold(st_name[8*i +: 8]);
      q = fold(q_name_r[8*i +: 8]);
      if (!done) begin
        if (q == 8'h00) begin
          hit  = (s == 8'h00);
          done = 1'b1;
        end else if (s != q) begin
          hit  = 1'b0;
          done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pend_idx_nxt = pend_idx_r;
    q_name_nxt   = q_name_r;
    q_long_nxt   = q_long_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = pend_idx_r;
    res_strobe   = 1'b0;
    res_found    = 1'b0;
    res_idx      = '0;
    res_pos      = '0;
    res_size     = '0;
    case (state_r)
      lndl_pkg::B_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.word.op == lndl_pkg::REQ_LOAD) begin
            ram_we = 1'b1;
          end else begin
            q_name_nxt = head.word.name;
            q_long_nxt = head.word.too_long;
            if (cnt_sat == '0) begin
              res_strobe = 1'b1;
            end else begin
              ram_re       = 1'b1;
              ram_raddr    = last_addr;
              pend_idx_nxt = last_addr;
              state_nxt    = lndl_pkg::B_SCAN;
            end
          end
        end
      end
      lndl_pkg::B_SCAN: begin
        if (hit) begin
          res_strobe = 1'b1;
          res_found  = 1'b1;
          res_idx    = pend_idx_r;
          res_pos    = st_pos;
          res_size   = st_size;
          state_nxt  = lndl_pkg::B_IDLE;
        end else if (pend_idx_r == '0) begin
          res_strobe = 1'b1;
          state_nxt  = lndl_pkg::B_IDLE;
        end else begin
          ram_re       = 1'b1;
          ram_raddr    = pend_idx_r - AW'(1);
          pend_idx_nxt = pend_idx_r - AW'(1);
        end
      end
      default: begin
        state_nxt = lndl_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lndl_pkg::B_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= res_strobe;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    q_name_r   <= q_name_nxt;
    q_long_r   <= q_long_nxt;
    found_r    <= res_found;
    idx_r      <= lndl_pkg::IDX_W'(res_idx);
    pos_r      <= res_pos;
    size_r     <= res_size;
  end

  assign out_strobe      = strobe_r;
  assign out_found       = found_r;
  assign out_match_index = idx_r;
  assign out_match_pos   = pos_r;
  assign out_match_size  = size_r;

endmodule

// File: rtl/core/lump_name_directory_lookup.sv
// top level of the case-insensitive name directory lookup block
//
//  channel   handshake              word
//  --------  ---------------------  -----------------------------------------------
//  in_       start && !busy         req_type, entry_index, entry_pos, entry_size,
//                                   name_bytes, name_too_long
//  out_      out_strobe, 1 cycle    found, match_index, match_pos, match_size
//  cfg_      cfg_wr_en              cfg_wr_data = entry_count
//
//  a load is written into the directory ram as it leaves the queue; a lookup reads
//  one directory ram entry per cycle, walking from entry_count-1 down to the first
//  match or to entry 0, and then registers the result; the back end takes no new
//  command word until the walk ends; the directory ram has a single read port
//  busy rises only when the two-word queue between front and back is full
//  reset (rst_n low, synchronous) empties the queue, idles the back end and
//  clears entry_count; the directory itself is undefined until loaded
//  the receiver cannot stall: each result word sits on out_ for exactly one cycle
module lump_name_directory_lookup #(
  parameter int DIR_DEPTH  = 4096,
  parameter int NAME_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command word
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [lndl_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [lndl_pkg::DATA_W-1:0] in_entry_pos,
  input  logic [lndl_pkg::DATA_W-1:0] in_entry_size,
  input  logic [lndl_pkg::NAME_W-1:0] in_name_bytes,
  input  logic                        in_name_too_long,
  // result word
  output logic                        out_strobe,
  output logic                        out_found,
  output logic [lndl_pkg::IDX_W-1:0]  out_match_index,
  output logic [lndl_pkg::DATA_W-1:0] out_match_pos,
  output logic [lndl_pkg::DATA_W-1:0] out_match_size,
  // entry_count register
  input  logic                        cfg_wr_en,
  input  logic [lndl_pkg::CNT_W-1:0]  cfg_wr_data
);

  // number of directory entries searched by a lookup (the back caps it at DIR_DEPTH)
  logic [lndl_pkg::CNT_W-1:0] entry_count_r, entry_count_nxt;

  // front to queue
  logic              q_push;
  logic              q_full;
  lndl_pkg::q_word_t q_word;

  // queue to back
  logic              q_pop;
  lndl_pkg::q_head_t q_head;

  assign entry_count_nxt = cfg_wr_en ? cfg_wr_data : entry_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  // front: accepts command words and drops loads past the directory end
  lndl_front #(
    .DIR_DEPTH (DIR_DEPTH)
  ) u_front (
    .start            (start),
    .q_full           (q_full),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_entry_pos     (in_entry_pos),
    .in_entry_size    (in_entry_size),
    .in_name_bytes    (in_name_bytes),
    .in_name_too_long (in_name_too_long),
    .q_push           (q_push),
    .q_word           (q_word)
  );

  // short queue keeps command order between front and back
  lndl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // back: directory ram writes and the descending lookup walk
  lndl_back #(
    .DIR_DEPTH  (DIR_DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .pop             (q_pop),
    .entry_count     (entry_count_r),
    .out_strobe      (out_strobe),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .out_match_pos   (out_match_pos),
    .out_match_size  (out_match_size)
  );

endmodule
